// File: rtl/apci_pkg.sv
// ----------------------------------------------------------------------------
// apci_pkg
// Shared types and constants for the APCI frame delimiter.
// ----------------------------------------------------------------------------
package apci_pkg;

    // result queue between the header parser and the output stage
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    // the parser writes at most this many transactions per input byte
    localparam int MAX_PUSH    = 3;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_CTRL,
        PH_BODY
    } phase_t;

    localparam logic [1:0] KIND_I = 2'd0;
    localparam logic [1:0] KIND_S = 2'd1;
    localparam logic [1:0] KIND_U = 2'd2;

    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_MAX_LENGTH = 1'b1;

    localparam logic [7:0] START_BYTE_RESET = 8'h68;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'hFD;
    localparam logic [7:0] MIN_I_LENGTH     = 8'd4;
    // body bytes after the header of an S or U frame (6 total minus 3 header)
    localparam logic [7:0] SHORT_BODY_LEFT  = 8'd3;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [1:0] frame_kind;
        logic       is_first;
        logic       is_last;
    } beat_t;

    typedef struct packed {
        logic [1:0]  push_n;
        beat_t [2:0] beats;
    } push_t;

endpackage

// File: rtl/apci_frame_delimiter.sv
// ----------------------------------------------------------------------------
// apci_frame_delimiter
// Results of an accepted byte pass through the result queue to the master
// register. Throughput: one byte per cycle in while s_tready is high and one
// transaction per cycle out while m_tready is high; s_tready drops while the
// 8-entry queue holds more than five entries.
// Reset: synchronous on aresetn low; hunts for the start byte, queue empty,
// registers at start byte 0x68 and maximum length byte 0xFD.
// ----------------------------------------------------------------------------
module apci_frame_delimiter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] frame_byte
    output logic [2:0]  m_tuser,    // [1:0] frame_kind, [2] is_first
    output logic        m_tlast     // is_last
);
    import apci_pkg::*;

    push_t push;
    beat_t head;
    logic  not_empty;
    logic  space_ok;
    logic  pop;

    apci_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .space_ok  (space_ok),
        .push      (push)
    );

    apci_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .space_ok  (space_ok)
    );

    apci_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: rtl/apci_front.sv
// ----------------------------------------------------------------------------
// apci_front
// Input side: configuration registers, frame hunting and header parsing.
// Writes zero, one or three result transactions per accepted byte.
// ----------------------------------------------------------------------------
module apci_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] rx_byte
    input  logic                space_ok,
    output apci_pkg::push_t     push
);
    import apci_pkg::*;

    logic [7:0] start_byte_reg;
    logic [7:0] max_length_reg;
    phase_t     phase_reg, phase_next;
    logic [7:0] held_length_reg, held_length_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [1:0] held_kind_reg, held_kind_next;

    logic       accept;
    logic [7:0] rx;
    logic [1:0] ctrl_kind;
    logic       short_i;
    logic       body_last;

    assign s_tready  = space_ok;
    assign accept    = s_tvalid && space_ok;
    assign rx        = s_tdata;
    assign ctrl_kind = (rx[1:0] == 2'b11) ? KIND_U : (rx[0] ? KIND_S : KIND_I);
    assign short_i   = (ctrl_kind == KIND_I) && (held_length_reg < MIN_I_LENGTH);
    assign body_last = (bytes_left_reg <= 8'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_BYTE_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_START_BYTE: start_byte_reg <= cfg_wdata;
                REG_MAX_LENGTH: max_length_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_length_reg <= '0;
            bytes_left_reg  <= '0;
            held_kind_reg   <= KIND_I;
        end else begin
            held_length_reg <= held_length_next;
            bytes_left_reg  <= bytes_left_next;
            held_kind_reg   <= held_kind_next;
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (rx == start_byte_reg) phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if (rx > max_length_reg) begin
                        // a rejected length byte may itself open a new frame
                        phase_next = (rx == start_byte_reg) ? PH_LEN : PH_HUNT;
                    end else begin
                        phase_next = PH_CTRL;
                    end
                end
                PH_CTRL: begin
                    phase_next = short_i ? PH_HUNT : PH_BODY;
                end
                PH_BODY: begin
                    if (body_last) phase_next = PH_HUNT;
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    // outputs and held fields
    always_comb begin
        held_length_next = held_length_reg;
        bytes_left_next  = bytes_left_reg;
        held_kind_next   = held_kind_reg;
        push.push_n      = 2'd0;
        push.beats[0]    = '{frame_byte: start_byte_reg, frame_kind: ctrl_kind,
                             is_first: 1'b1, is_last: 1'b0};
        push.beats[1]    = '{frame_byte: held_length_reg, frame_kind: ctrl_kind,
                             is_first: 1'b0, is_last: 1'b0};
        push.beats[2]    = '{frame_byte: rx, frame_kind: ctrl_kind,
                             is_first: 1'b0, is_last: 1'b0};
        if (accept) begin
            case (phase_reg)
                PH_LEN: begin
                    if (rx <= max_length_reg) held_length_next = rx;
                end
                PH_CTRL: begin
                    if (!short_i) begin
                        held_kind_next  = ctrl_kind;
                        bytes_left_next = (ctrl_kind == KIND_I) ?
                                          (held_length_reg - 8'd1) : SHORT_BODY_LEFT;
                        push.push_n     = 2'd3;
                    end
                end
                PH_BODY: begin
                    push.beats[0]   = '{frame_byte: rx, frame_kind: held_kind_reg,
                                        is_first: 1'b0, is_last: body_last};
                    push.push_n     = 2'd1;
                    bytes_left_next = body_last ? 8'd0 : (bytes_left_reg - 8'd1);
                end
                default: ;
            endcase
        end
    end

    a_no_two_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push_n != 2'd2)
        else $error("parser wrote two transactions for one byte");

    a_header_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.push_n == 2'd3) |-> (push.beats[0].is_first && !push.beats[2].is_last
                                   && phase_reg == PH_CTRL))
        else $error("header written outside control phase or with wrong marks");

endmodule

// File: rtl/apci_fifo.sv
// ----------------------------------------------------------------------------
// apci_fifo
// Short result queue: up to three writes and one read per cycle.
// ----------------------------------------------------------------------------
module apci_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  apci_pkg::push_t     push,
    input  logic                pop,
    output apci_pkg::beat_t     head,
    output logic                not_empty,
    output logic                space_ok
);
    import apci_pkg::*;

    beat_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign space_ok  = (count_reg <= CNT_W'(QUEUE_DEPTH - MAX_PUSH));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.push_n) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (k < int'(push.push_n)) begin
                mem[wr_ptr_reg + PTR_W'(k)] <= push.beats[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.push_n != 2'd0) |-> (count_reg <= CNT_W'(QUEUE_DEPTH - MAX_PUSH)))
        else $error("write into result queue without room for a header");

endmodule

// File: rtl/apci_back.sv
// ----------------------------------------------------------------------------
// apci_back
// Output stage: takes one queued transaction at a time into the master
// register and holds it until the sink takes it.
// ----------------------------------------------------------------------------
module apci_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  apci_pkg::beat_t     head,
    input  logic                not_empty,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // [7:0] frame_byte
    output logic [2:0]          m_tuser,    // [1:0] frame_kind, [2] is_first
    output logic                m_tlast     // is_last
);
    import apci_pkg::*;

    logic  m_tvalid_reg;
    beat_t beat_reg;

    assign pop      = not_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = beat_reg.frame_byte;
    assign m_tuser  = {beat_reg.is_first, beat_reg.frame_kind};
    assign m_tlast  = beat_reg.is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= not_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            beat_reg <= head;
        end
    end

endmodule
